// File: sv/dfpa_pkg.sv
// ============================================================================
// dfpa_pkg
// Shared types and constants of the distance frame parser and averager.
// ============================================================================
package dfpa_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;

    localparam int DIST_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HUNT_LIMIT   = 1'b1;

    localparam logic [DIST_W-1:0] MIN_DISTANCE_RESET = 16'd30;
    localparam logic [BYTE_W-1:0] HUNT_LIMIT_RESET   = 8'd21;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HIGH,
        PH_LOW,
        PH_SUM
    } phase_t;

    typedef enum logic [1:0] {
        ST_VALID,
        ST_BAD_SUM,
        ST_BELOW_MIN,
        ST_NO_HEADER
    } status_t;

    // Per-byte event from the parser to the ring and result stage
    typedef struct packed {
        logic              emit;
        logic              store;
        status_t           status;
        logic [DIST_W-1:0] distance;
    } frame_evt_t;

endpackage

// File: sv/distance_frame_parser_averager.sv
// Path: a byte that completes a frame or ends a hunt reaches its result
// through the byte register, the parse and ring stage and the result
// register, in that order.
// Throughput: one byte per cycle; the three stages stall only when the
// result register is full and not taken.
// Reset: asynchronous, active low; parser in hunt, ring and sum cleared,
// min_distance 30, hunt_limit 21.
// ============================================================================
// distance_frame_parser_averager
// Parses header/high/low/checksum frames from a sensor byte stream and
// reports status, raw distance and the moving average of good readings.
// ============================================================================
module distance_frame_parser_averager #(
    parameter int AVG_DEPTH = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [dfpa_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [dfpa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dfpa_pkg::BYTE_W-1:0]         rx_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [dfpa_pkg::DIST_W-1:0]         distance,
    output logic [dfpa_pkg::DIST_W-1:0]         average
);

    localparam int SUM_W = dfpa_pkg::DIST_W + $clog2(AVG_DEPTH);

    logic [dfpa_pkg::DIST_W-1:0]  min_distance_reg;
    logic [dfpa_pkg::BYTE_W-1:0]  hunt_limit_reg;

    logic                         byte_valid_reg;
    logic [dfpa_pkg::BYTE_W-1:0]  byte_reg;

    logic                         mid_valid_reg;
    dfpa_pkg::status_t            mid_status_reg;
    logic [dfpa_pkg::DIST_W-1:0]  mid_distance_reg;
    logic [SUM_W-1:0]             mid_sum_reg;

    logic                         mid_ready;
    logic                         div_ready;
    logic                         step;
    dfpa_pkg::frame_evt_t         evt;
    logic [SUM_W-1:0]             ring_sum;

    assign mid_ready = !mid_valid_reg || div_ready;
    assign step      = byte_valid_reg && mid_ready;
    assign in_ready  = !byte_valid_reg || mid_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg <= dfpa_pkg::MIN_DISTANCE_RESET;
            hunt_limit_reg   <= dfpa_pkg::HUNT_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                dfpa_pkg::REG_MIN_DISTANCE: min_distance_reg <= cfg_wdata;
                dfpa_pkg::REG_HUNT_LIMIT:
                    hunt_limit_reg <= cfg_wdata[dfpa_pkg::BYTE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            mid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                byte_valid_reg <= in_valid;
            end
            if (mid_ready)
            begin
                mid_valid_reg <= step && evt.emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
        if (step && evt.emit)
        begin
            mid_status_reg   <= evt.status;
            mid_distance_reg <= evt.distance;
            mid_sum_reg      <= ring_sum;
        end
    end

    dfpa_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .rx_byte      (byte_reg),
        .min_distance (min_distance_reg),
        .hunt_limit   (hunt_limit_reg),
        .evt          (evt)
    );

    dfpa_ring #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt),
        .sum_out (ring_sum)
    );

    dfpa_avg_div #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_avg_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (mid_valid_reg),
        .in_ready    (div_ready),
        .in_status   (mid_status_reg),
        .in_distance (mid_distance_reg),
        .in_sum      (mid_sum_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .distance    (distance),
        .average     (average)
    );

endmodule

// File: sv/dfpa_parser.sv
// ============================================================================
// dfpa_parser
// Frame state machine: header hunt, high byte, low byte, checksum check.
// ============================================================================
module dfpa_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [dfpa_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [dfpa_pkg::DIST_W-1:0]   min_distance,
    input  logic [dfpa_pkg::BYTE_W-1:0]   hunt_limit,
    output dfpa_pkg::frame_evt_t          evt
);

    dfpa_pkg::phase_t                phase_reg, phase_next;
    logic [dfpa_pkg::BYTE_W-1:0]     high_reg, high_next;
    logic [dfpa_pkg::BYTE_W-1:0]     low_reg, low_next;
    logic [dfpa_pkg::BYTE_W-1:0]     hunt_reg, hunt_next;
    logic [dfpa_pkg::BYTE_W:0]       hunt_inc;
    logic [dfpa_pkg::BYTE_W-1:0]     checksum;
    logic [dfpa_pkg::DIST_W-1:0]     frame_dist;

    assign hunt_inc   = {1'b0, hunt_reg} + 9'd1;
    assign checksum   = high_reg + low_reg + dfpa_pkg::HEADER_BYTE;
    assign frame_dist = {high_reg, low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dfpa_pkg::PH_HUNT;
            high_reg  <= '0;
            low_reg   <= '0;
            hunt_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            hunt_reg  <= hunt_next;
        end
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                dfpa_pkg::PH_HUNT:
                begin
                    if (rx_byte == dfpa_pkg::HEADER_BYTE)
                    begin
                        phase_next = dfpa_pkg::PH_HIGH;
                    end
                end
                dfpa_pkg::PH_HIGH: phase_next = dfpa_pkg::PH_LOW;
                dfpa_pkg::PH_LOW:  phase_next = dfpa_pkg::PH_SUM;
                dfpa_pkg::PH_SUM:  phase_next = dfpa_pkg::PH_HUNT;
            endcase
        end
    end

    // Outputs and data registers
    always_comb
    begin
        evt       = '0;
        high_next = high_reg;
        low_next  = low_reg;
        hunt_next = hunt_reg;
        if (step)
        begin
            unique case (phase_reg)
                dfpa_pkg::PH_HUNT:
                begin
                    if (rx_byte == dfpa_pkg::HEADER_BYTE)
                    begin
                        hunt_next = '0;
                    end
                    else if (hunt_inc >= {1'b0, hunt_limit})
                    begin
                        // hunt ran out: report with no distance
                        hunt_next  = '0;
                        evt.emit   = 1'b1;
                        evt.status = dfpa_pkg::ST_NO_HEADER;
                    end
                    else
                    begin
                        hunt_next = hunt_inc[dfpa_pkg::BYTE_W-1:0];
                    end
                end
                dfpa_pkg::PH_HIGH: high_next = rx_byte;
                dfpa_pkg::PH_LOW:  low_next  = rx_byte;
                dfpa_pkg::PH_SUM:
                begin
                    hunt_next    = '0;
                    evt.emit     = 1'b1;
                    evt.distance = frame_dist;
                    if (checksum != rx_byte)
                    begin
                        evt.status = dfpa_pkg::ST_BAD_SUM;
                    end
                    else if (frame_dist <= min_distance)
                    begin
                        evt.status = dfpa_pkg::ST_BELOW_MIN;
                    end
                    else
                    begin
                        evt.status = dfpa_pkg::ST_VALID;
                        evt.store  = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

// File: sv/dfpa_ring.sv
// ============================================================================
// dfpa_ring
// Ring of recent good readings with a running sum of its entries.
// ============================================================================
module dfpa_ring #(
    parameter int AVG_DEPTH = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dfpa_pkg::frame_evt_t      evt,
    output logic [dfpa_pkg::DIST_W+$clog2(AVG_DEPTH)-1:0] sum_out
);

    localparam int SUM_W = dfpa_pkg::DIST_W + $clog2(AVG_DEPTH);
    localparam int PTR_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AVG_DEPTH - 1);

    logic [dfpa_pkg::DIST_W-1:0] entry_reg [AVG_DEPTH];
    logic [PTR_W-1:0]            ptr_reg, ptr_adv;
    logic                        have_reg;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic [SUM_W-1:0]            fill_sum, roll_sum;

    // advance first, then write
    assign ptr_adv  = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
    assign fill_sum = SUM_W'(SUM_W'(evt.distance) * SUM_W'(AVG_DEPTH));
    assign roll_sum = sum_reg - SUM_W'(entry_reg[ptr_adv]) + SUM_W'(evt.distance);

    always_comb
    begin
        sum_next = sum_reg;
        if (evt.store)
        begin
            sum_next = have_reg ? roll_sum : fill_sum;
        end
    end

    assign sum_out = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AVG_DEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
            ptr_reg  <= '0;
            have_reg <= 1'b0;
            sum_reg  <= '0;
        end
        else if (evt.store)
        begin
            ptr_reg  <= ptr_adv;
            have_reg <= 1'b1;
            sum_reg  <= sum_next;
            if (have_reg)
            begin
                entry_reg[ptr_adv] <= evt.distance;
            end
            else
            begin
                // first good reading fills every slot
                for (int i = 0; i < AVG_DEPTH; i++)
                begin
                    entry_reg[i] <= evt.distance;
                end
            end
        end
    end

endmodule

// File: sv/dfpa_avg_div.sv
// ============================================================================
// dfpa_avg_div
// Result register: divides the ring sum by the ring depth with a
// reciprocal multiply and holds the finished result for the output transfer.
// ============================================================================
module dfpa_avg_div #(
    parameter int AVG_DEPTH = 3
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  dfpa_pkg::status_t                         in_status,
    input  logic [dfpa_pkg::DIST_W-1:0]               in_distance,
    input  logic [dfpa_pkg::DIST_W+$clog2(AVG_DEPTH)-1:0] in_sum,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [1:0]                                status,
    output logic [dfpa_pkg::DIST_W-1:0]               distance,
    output logic [dfpa_pkg::DIST_W-1:0]               average
);

    localparam int L_W   = $clog2(AVG_DEPTH);
    localparam int SUM_W = dfpa_pkg::DIST_W + L_W;
    localparam int SHIFT = SUM_W + L_W;
    // ceil(2^SHIFT / depth) gives an exact quotient for every SUM_W-bit sum
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
    localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];

    logic [2*SUM_W:0]             product;
    logic                         out_valid_reg;
    logic [1:0]                   status_reg;
    logic [dfpa_pkg::DIST_W-1:0]  distance_reg;
    logic [dfpa_pkg::DIST_W-1:0]  average_reg;

    assign product  = (2*SUM_W+1)'(in_sum) * (2*SUM_W+1)'(RECIP);
    assign in_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            status_reg   <= in_status;
            distance_reg <= in_distance;
            average_reg  <= product[SHIFT +: dfpa_pkg::DIST_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign distance  = distance_reg;
    assign average   = average_reg;

endmodule

// File: sv/dfpa_checker.sv
// ============================================================================
// dfpa_checker
// Port-level checks of the distance frame parser and averager.
// ============================================================================
module dfpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  rx_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [15:0] distance,
    input logic [15:0] average
);

    // a waiting byte holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(rx_byte))
        else $error("input byte changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(distance) && $stable(average))
        else $error("result changed while stalled");

    a_no_header_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == dfpa_pkg::ST_NO_HEADER |-> distance == 16'd0)
        else $error("no-header result carries a distance");

    // a good reading exceeds min_distance, so it is never zero
    a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == dfpa_pkg::ST_VALID |-> distance != 16'd0)
        else $error("valid reading with zero distance");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind distance_frame_parser_averager dfpa_checker u_checker (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Feeds framed, broken and noisy sensor byte streams into the distance frame
// parser under several register settings and flow-control mixes, and checks
// every status, distance and ring average against a byte-level model.
// ============================================================================
import dfpa_pkg::*;

localparam int RING_DEPTH = 3;

typedef struct packed {
    status_t           status;
    logic [DIST_W-1:0] distance;
    logic [DIST_W-1:0] average;
} frame_report_t;

class distance_average_tracker;
    logic [DIST_W-1:0] min_distance;
    logic [BYTE_W-1:0] hunt_limit;
    phase_t            phase;
    logic [BYTE_W-1:0] high_byte;
    logic [BYTE_W-1:0] low_byte;
    logic [8:0]        hunt_count;
    logic [DIST_W-1:0] readings [0:RING_DEPTH-1];
    int unsigned       ring_ptr;
    bit                have_reading;
    frame_report_t     due_reports [$];
    int unsigned       mismatches;

    function new();
        min_distance = MIN_DISTANCE_RESET;
        hunt_limit   = HUNT_LIMIT_RESET;
        phase        = PH_HUNT;
        high_byte    = '0;
        low_byte     = '0;
        hunt_count   = '0;
        foreach (readings[i])
            readings[i] = '0;
        ring_ptr     = 0;
        have_reading = 1'b0;
        mismatches   = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        if (addr == REG_MIN_DISTANCE)
            min_distance = data;
        else if (addr == REG_HUNT_LIMIT)
            hunt_limit = data[BYTE_W-1:0];
    endfunction

    function void post(status_t st, logic [DIST_W-1:0] dist_word);
        frame_report_t rep;
        int unsigned   total;
        total = 0;
        foreach (readings[i])
            total += readings[i];
        rep.status   = st;
        rep.distance = dist_word;
        rep.average  = DIST_W'(total / RING_DEPTH);
        due_reports.push_back(rep);
    endfunction

    function void store_reading(logic [DIST_W-1:0] dist_word);
        // advance first, then write; the first good reading floods the ring
        ring_ptr = (ring_ptr + 1 >= RING_DEPTH) ? 0 : ring_ptr + 1;
        readings[ring_ptr] = dist_word;
        if (!have_reading)
        begin
            foreach (readings[i])
                readings[i] = dist_word;
            have_reading = 1'b1;
        end
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
        logic [DIST_W-1:0] dist_word;
        logic [BYTE_W-1:0] sum;
        case (phase)
            PH_HUNT:
                if (b == HEADER_BYTE)
                begin
                    hunt_count = '0;
                    phase      = PH_HIGH;
                end
                else
                begin
                    hunt_count = hunt_count + 9'd1;
                    if (hunt_count >= hunt_limit)
                    begin
                        hunt_count = '0;
                        post(ST_NO_HEADER, '0);
                    end
                end
            PH_HIGH:
                begin
                    high_byte = b;
                    phase     = PH_LOW;
                end
            PH_LOW:
                begin
                    low_byte = b;
                    phase    = PH_SUM;
                end
            default:
                begin
                    phase      = PH_HUNT;
                    hunt_count = '0;
                    dist_word  = {high_byte, low_byte};
                    sum        = high_byte + low_byte + HEADER_BYTE;
                    if (sum != b)
                        post(ST_BAD_SUM, dist_word);
                    else if (dist_word <= min_distance)
                        post(ST_BELOW_MIN, dist_word);
                    else
                    begin
                        store_reading(dist_word);
                        post(ST_VALID, dist_word);
                    end
                end
        endcase
    endfunction

    function void complain(string msg);
        mismatches++;
        // cap the log on a badly broken block
        if (mismatches <= 200)
            $display("%s", msg);
    endfunction

    function void check_report(logic [1:0] st, logic [DIST_W-1:0] dist_word,
                               logic [DIST_W-1:0] avg);
        frame_report_t due;
        if (due_reports.size() == 0)
        begin
            complain($sformatf({"%0t: unexpected report, expected none, ",
                                "got status %0d distance %0d average %0d"},
                               $time, st, dist_word, avg));
            return;
        end
        due = due_reports.pop_front();
        if (due.status != st)
            complain($sformatf("%0t: status expected %0d got %0d",
                               $time, due.status, st));
        if (due.distance != dist_word)
            complain($sformatf("%0t: distance expected %0d got %0d",
                               $time, due.distance, dist_word));
        if (due.average != avg)
            complain($sformatf("%0t: average expected %0d got %0d",
                               $time, due.average, avg));
    endfunction
endclass

module tb_top;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int PHASE_BYTES    = 144;

    // below minimum at zero, all-ones data (header value inside a frame) that
    // fills the ring, first distance over the minimum, bad checksum, distance
    // equal to the minimum
    localparam logic [7:0] OPENING_FRAMES [0:19] = '{
        8'hFF, 8'h00, 8'h00, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFD,
        8'hFF, 8'h00, 8'h1F, 8'h1E,
        8'hFF, 8'h12, 8'h34, 8'h00,
        8'hFF, 8'h00, 8'h1E, 8'h1D
    };
    // with a hunt limit of zero every non-header byte ends the hunt
    localparam logic [7:0] ZERO_LIMIT_BYTES [0:6] = '{
        8'h00, 8'h80, 8'h7F,
        8'hFF, 8'h00, 8'h01, 8'h00
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   in_valid;
    logic                   in_ready;
    logic [BYTE_W-1:0]      rx_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             status;
    logic [DIST_W-1:0]      distance;
    logic [DIST_W-1:0]      average;

    int unsigned            gap_pct;
    int unsigned            stall_pct;
    int unsigned            idle_cycles = 0;
    int unsigned            phase_bytes;
    logic [DIST_W-1:0]      cur_min;
    logic [BYTE_W-1:0]      cur_limit;
    distance_average_tracker tracker;

    distance_frame_parser_averager #(
        .AVG_DEPTH (RING_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .distance  (distance),
        .average   (average)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_report(status, distance, average);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        do @(posedge clk); while (!in_ready);
        tracker.note_byte(value);
        phase_bytes++;
    endtask

    // any_byte lets header values in, which breaks frames at random points
    task automatic send_noise(input int unsigned count, input bit any_byte);
        logic [BYTE_W-1:0] b;
        repeat (count)
        begin
            b = any_byte ? BYTE_W'($urandom_range(255)) : BYTE_W'($urandom_range(254));
            send_byte(b);
        end
    endtask

    task automatic send_frame();
        logic [DIST_W-1:0] dist_word;
        logic [BYTE_W-1:0] check;
        logic [BYTE_W-1:0] flip;
        case ($urandom_range(9))
            0: dist_word = cur_min;
            1: dist_word = cur_min + 16'd1;
            2: dist_word = 16'd0;
            3: dist_word = 16'hFFFF;
            default: dist_word = DIST_W'($urandom_range(65535));
        endcase
        check = dist_word[15:8] + dist_word[7:0] + HEADER_BYTE;
        if ($urandom_range(99) < 20)
        begin
            flip  = BYTE_W'($urandom_range(1, 255));
            check = check ^ flip;
        end
        send_byte(HEADER_BYTE);
        send_byte(dist_word[15:8]);
        send_byte(dist_word[7:0]);
        send_byte(check);
    endtask

    // drop valid, drain all reports, then cover bytes still in the pipe
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.due_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] min_word,
                                input logic [CFG_DATA_W-1:0] limit_word);
        cfg_write <= 1'b1;
        cfg_addr  <= REG_MIN_DISTANCE;
        cfg_wdata <= min_word;
        @(posedge clk);
        cfg_addr  <= REG_HUNT_LIMIT;
        cfg_wdata <= limit_word;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.write_register(REG_MIN_DISTANCE, min_word);
        tracker.write_register(REG_HUNT_LIMIT, limit_word);
        cur_min   = min_word;
        cur_limit = limit_word[BYTE_W-1:0];
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] min_word;
        logic [CFG_DATA_W-1:0] limit_word;
        int unsigned           pick;

        tracker     = new();
        gap_pct     = 0;
        stall_pct   = 0;
        phase_bytes = 0;
        cur_min     = MIN_DISTANCE_RESET;
        cur_limit   = HUNT_LIMIT_RESET;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_addr  <= REG_MIN_DISTANCE;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPENING_FRAMES[i])
            send_byte(OPENING_FRAMES[i]);
        settle();
        apply_config(16'd0, 16'h0100);
        foreach (ZERO_LIMIT_BYTES[i])
            send_byte(ZERO_LIMIT_BYTES[i]);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    min_word = 16'd30;   limit_word = 16'd21;   gap_pct = 0;  stall_pct = 0;
                end
                1:
                begin
                    min_word = 16'd0;    limit_word = 16'h0001; gap_pct = 86; stall_pct = 0;
                end
                2:
                begin
                    min_word = 16'hFFFF; limit_word = 16'h00FF; gap_pct = 0;  stall_pct = 86;
                end
                3:
                begin
                    min_word   = CFG_DATA_W'($urandom_range(65535));
                    limit_word = CFG_DATA_W'($urandom_range(1, 40));
                    gap_pct    = 24;
                    stall_pct  = 24;
                end
                4:
                begin
                    min_word = 16'h7FFF; limit_word = 16'hA503; gap_pct = 0;  stall_pct = 0;
                end
                5:
                begin
                    min_word = 16'd1000; limit_word = 16'h0100; gap_pct = 86; stall_pct = 0;
                end
                6:
                begin
                    min_word   = CFG_DATA_W'($urandom_range(65535));
                    limit_word = CFG_DATA_W'($urandom_range(2, 24));
                    gap_pct    = 0;
                    stall_pct  = 86;
                end
                default:
                begin
                    min_word   = CFG_DATA_W'($urandom_range(4095));
                    limit_word = CFG_DATA_W'($urandom_range(65535));
                    gap_pct    = 24;
                    stall_pct  = 24;
                end
            endcase
            apply_config(min_word, limit_word);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_frame();
                else if (pick < 84)
                    send_noise($urandom_range(1, 4), 1'b0);
                else if (pick < 93)
                    send_noise($urandom_range(1, 6), 1'b1);
                else
                    send_noise(cur_limit + $urandom_range(0, 2), 1'b0);
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.due_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
